[hw/rtl/text_console_writer_top_assert.svh]
// assertion macros for the text console writer
// used by the control module; expects clk_i and rst_ni in scope
`ifndef TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH

// property must hold at every clock edge outside reset
`define TCW_ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition must never be true
`define TCW_ASSERT_NEVER(label, cond, msg) \
  `TCW_ASSERT_PROP(label, !(cond), msg)

`endif

[hw/rtl/tcw_pkg.sv]
// shared constants, types and helper functions of the text console writer
// no dependencies; imported by the interfaces, tcw_cfg, tcw_ctrl and the top level
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  // screen geometry
  localparam int unsigned SCREEN_COLUMNS = 80;
  localparam int unsigned SCREEN_ROWS    = 25;
  localparam int unsigned TAB_STOP       = 8;
  localparam int unsigned CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;

  // derived widths
  localparam int unsigned ADDR_W = $clog2(CELL_COUNT);
  localparam int unsigned POS_W  = $clog2(CELL_COUNT + 1);
  localparam int unsigned COL_W  = $clog2(SCREEN_COLUMNS);
  localparam int unsigned TAB_W  = $clog2(TAB_STOP + 1);
  localparam int unsigned NL_W   = $clog2(SCREEN_COLUMNS + TAB_STOP);

  // fixed field widths
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned COLOR_W    = 4;
  localparam int unsigned ATTR_W     = 8;
  localparam int unsigned COORD_W    = 8;
  localparam int unsigned RIDX_W     = 11;
  localparam int unsigned CELL_W     = 16;
  localparam int unsigned CURSOR_W   = 11;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  // positions used by scroll and saturation
  localparam int unsigned SCROLL_POS    = CELL_COUNT - SCREEN_COLUMNS;
  localparam int unsigned END_TAB_PH    = CELL_COUNT % TAB_STOP;
  localparam int unsigned SCROLL_TAB_PH = (SCROLL_POS + 1) % TAB_STOP;

  // control characters
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FG    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLANK = 2'd2;

  // operation codes
  typedef enum logic [1:0] {
    FUNC_PUT   = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_PLACE = 2'd3
  } func_e;

  // configuration register values
  typedef struct packed {
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
    logic [ATTR_W-1:0]  blank;
  } cfg_t;

  // screen store access request
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // reduce a small value modulo the tab stop by shifted subtracts
  function automatic logic [TAB_W-1:0] tab_mod(input logic [NL_W-1:0] v);
    logic [NL_W+4:0] r;
    r = (NL_W+5)'(v);
    for (int k = NL_W - 1; k >= 0; k--) begin
      if (r >= ((NL_W+5)'(TAB_STOP) << k)) begin
        r = r - ((NL_W+5)'(TAB_STOP) << k);
      end
    end
    return r[TAB_W-1:0];
  endfunction

  // fold a column sum below twice the screen width back into range
  function automatic logic [COL_W-1:0] col_wrap(input logic [NL_W-1:0] v);
    logic [NL_W:0] r;
    r = (NL_W+1)'(v);
    if (r >= (NL_W+1)'(2 * SCREEN_COLUMNS)) begin
      r = r - (NL_W+1)'(2 * SCREEN_COLUMNS);
    end
    if (r >= (NL_W+1)'(SCREEN_COLUMNS)) begin
      r = r - (NL_W+1)'(SCREEN_COLUMNS);
    end
    return r[COL_W-1:0];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/tcw_in_if.sv]
// request channel of the text console writer: valid, ready and item fields
// depends on tcw_pkg for field widths and the operation code type
`timescale 1ns / 1ps
`default_nettype none

interface tcw_in_if
  import tcw_pkg::*;
();
  logic               valid;
  logic               ready;
  func_e              func;
  logic [CHAR_W-1:0]  character;
  logic               last_char;
  logic [COORD_W-1:0] column;
  logic [COORD_W-1:0] row;
  logic [COLOR_W-1:0] place_fg;
  logic [COLOR_W-1:0] place_bg;
  logic [RIDX_W-1:0]  read_index;

  modport source (
    output valid, func, character, last_char, column, row, place_fg, place_bg,
           read_index,
    input  ready
  );

  modport sink (
    input  valid, func, character, last_char, column, row, place_fg, place_bg,
           read_index,
    output ready
  );
endinterface

`default_nettype wire

[hw/rtl/tcw_out_if.sv]
// result channel of the text console writer: valid, ready and result fields
// depends on tcw_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface tcw_out_if
  import tcw_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [CELL_W-1:0]   cell_data;
  logic [CURSOR_W-1:0] cursor_position;

  modport source (
    output valid, cell_data, cursor_position,
    input  ready
  );

  modport sink (
    input  valid, cell_data, cursor_position,
    output ready
  );
endinterface

`default_nettype wire

[hw/rtl/tcw_ram.sv]
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/tcw_cfg.sv]
// configuration registers: streamed colours and blank attribute
// depends on tcw_pkg for indexes and the cfg_t type
`timescale 1ns / 1ps
`default_nettype none

module tcw_cfg
  import tcw_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;

  // register writes, indexes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fg    <= 4'hF;
      cfg_q.bg    <= 4'h0;
      cfg_q.blank <= 8'h0F;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FG:    cfg_q.fg    <= cfg_data_i[COLOR_W-1:0];
        CFG_BG:    cfg_q.bg    <= cfg_data_i[COLOR_W-1:0];
        CFG_BLANK: cfg_q.blank <= cfg_data_i[ATTR_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[hw/rtl/tcw_ctrl.sv]
// control sequencer: write position tracking, screen store access, sweeps
// depends on tcw_pkg, both channel interfaces and the assertion macros
`timescale 1ns / 1ps
`default_nettype none
`include "text_console_writer_top_assert.svh"

module tcw_ctrl
  import tcw_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  tcw_in_if.sink            in_i,
  tcw_out_if.source         out_o,
  output mem_req_t          mem_o,
  input  logic [CELL_W-1:0] rd_data_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FIN,
    ST_RESP
  } state_e;

  state_e              state_q, state_d;
  logic [POS_W-1:0]    wp_q, wp_d;
  logic [COL_W-1:0]    col_q, col_d;
  logic [TAB_W-1:0]    ph_q, ph_d;
  logic [POS_W-1:0]    cur_q, cur_d;
  logic [POS_W-1:0]    sw_q, sw_d;
  logic                pend_q, pend_d;
  logic [ADDR_W-1:0]   pa_q, pa_d;
  logic                blank_q, blank_d;
  logic                clr_q, clr_d;
  logic                rd_hit_q, rd_hit_d;
  logic [CHAR_W-1:0]   chr_q, chr_d;
  logic                last_q, last_d;
  logic                out_valid_q, out_valid_d;
  logic [CELL_W-1:0]   out_cell_q, out_cell_d;
  logic [CURSOR_W-1:0] out_cur_q, out_cur_d;

  logic                acc;
  logic [TAB_W-1:0]    tab_step;
  logic [POS_W:0]      nl_pos;
  logic [POS_W:0]      tab_pos;
  logic [NL_W-1:0]     nl_ph_sum;
  logic [NL_W-1:0]     tab_col_sum;
  logic                place_ok;
  logic [ADDR_W-1:0]   place_addr;

  assign acc = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);

  // next newline and tab positions
  assign tab_step    = TAB_W'(TAB_STOP) - ph_q;
  assign nl_pos      = (POS_W+1)'(wp_q) + (POS_W+1)'(SCREEN_COLUMNS) - (POS_W+1)'(col_q);
  assign tab_pos     = (POS_W+1)'(wp_q) + (POS_W+1)'(tab_step);
  assign nl_ph_sum   = NL_W'(ph_q) + NL_W'(SCREEN_COLUMNS) - NL_W'(col_q);
  assign tab_col_sum = NL_W'(col_q) + NL_W'(tab_step);

  // placement address and range check
  assign place_ok   = (in_i.column < COORD_W'(SCREEN_COLUMNS)) &&
                      (in_i.row < COORD_W'(SCREEN_ROWS));
  assign place_addr = ADDR_W'(32'(in_i.row) * SCREEN_COLUMNS + 32'(in_i.column));

  // sequencer next state and store requests
  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    col_d       = col_q;
    ph_d        = ph_q;
    cur_d       = cur_q;
    sw_d        = sw_q;
    pend_d      = pend_q;
    pa_d        = pa_q;
    blank_d     = blank_q;
    clr_d       = clr_q;
    rd_hit_d    = rd_hit_q;
    chr_d       = chr_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_cell_d  = out_cell_q;
    out_cur_d   = out_cur_q;
    mem_o       = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          rd_hit_d = 1'b0;
          state_d  = ST_RESP;
          unique case (in_i.func)
            FUNC_PUT: begin
              if (in_i.character == CH_NEWLINE) begin
                // next row start, saturating at the cell count
                col_d = '0;
                if (nl_pos > (POS_W+1)'(CELL_COUNT)) begin
                  wp_d = POS_W'(CELL_COUNT);
                  ph_d = TAB_W'(END_TAB_PH);
                end else begin
                  wp_d = nl_pos[POS_W-1:0];
                  ph_d = tab_mod(nl_ph_sum);
                end
                if (in_i.last_char) begin
                  cur_d = wp_d;
                end
              end else if (in_i.character == CH_TAB) begin
                // next tab stop, saturating at the cell count
                if (tab_pos > (POS_W+1)'(CELL_COUNT)) begin
                  wp_d  = POS_W'(CELL_COUNT);
                  col_d = '0;
                  ph_d  = TAB_W'(END_TAB_PH);
                end else begin
                  wp_d  = tab_pos[POS_W-1:0];
                  col_d = col_wrap(tab_col_sum);
                  ph_d  = '0;
                end
                if (in_i.last_char) begin
                  cur_d = wp_d;
                end
              end else if (wp_q >= POS_W'(CELL_COUNT)) begin
                // off screen: scroll first, write the character afterwards
                chr_d   = in_i.character;
                last_d  = in_i.last_char;
                clr_d   = 1'b0;
                sw_d    = '0;
                pend_d  = 1'b0;
                state_d = ST_SWEEP;
              end else begin
                mem_o.we    = 1'b1;
                mem_o.waddr = wp_q[ADDR_W-1:0];
                mem_o.wdata = {cfg_i.bg, cfg_i.fg, in_i.character};
                wp_d        = wp_q + POS_W'(1);
                col_d = (col_q == COL_W'(SCREEN_COLUMNS - 1)) ? '0 : col_q + COL_W'(1);
                ph_d  = (ph_q == TAB_W'(TAB_STOP - 1)) ? '0 : ph_q + TAB_W'(1);
                if (in_i.last_char) begin
                  cur_d = wp_d;
                end
              end
            end
            FUNC_READ: begin
              if (in_i.read_index < RIDX_W'(CELL_COUNT)) begin
                mem_o.re    = 1'b1;
                mem_o.raddr = ADDR_W'(in_i.read_index);
                rd_hit_d    = 1'b1;
              end
            end
            FUNC_CLEAR: begin
              clr_d   = 1'b1;
              sw_d    = '0;
              pend_d  = 1'b0;
              state_d = ST_SWEEP;
            end
            FUNC_PLACE: begin
              if (place_ok) begin
                mem_o.we    = 1'b1;
                mem_o.waddr = place_addr;
                mem_o.wdata = {in_i.place_bg, in_i.place_fg, in_i.character};
              end
            end
          endcase
        end
      end
      ST_SWEEP: begin
        // write stage: copied row data or blank cell
        if (pend_q) begin
          mem_o.we    = 1'b1;
          mem_o.waddr = pa_q;
          mem_o.wdata = blank_q ? {cfg_i.blank, CHAR_W'(0)} : rd_data_i;
        end
        // issue stage: fetch the cell one row below
        if (sw_q < POS_W'(CELL_COUNT)) begin
          if (!clr_q && (sw_q < POS_W'(SCROLL_POS))) begin
            mem_o.re    = 1'b1;
            mem_o.raddr = ADDR_W'(sw_q + POS_W'(SCREEN_COLUMNS));
          end
          pend_d  = 1'b1;
          pa_d    = sw_q[ADDR_W-1:0];
          blank_d = clr_q || (sw_q >= POS_W'(SCROLL_POS));
          sw_d    = sw_q + POS_W'(1);
        end else begin
          pend_d  = 1'b0;
          state_d = clr_q ? ST_RESP : ST_FIN;
        end
      end
      ST_FIN: begin
        // character goes to the start of the freed last row
        mem_o.we    = 1'b1;
        mem_o.waddr = ADDR_W'(SCROLL_POS);
        mem_o.wdata = {cfg_i.bg, cfg_i.fg, chr_q};
        wp_d        = POS_W'(SCROLL_POS + 1);
        col_d       = COL_W'(1);
        ph_d        = TAB_W'(SCROLL_TAB_PH);
        if (last_q) begin
          cur_d = POS_W'(SCROLL_POS + 1);
        end
        state_d = ST_RESP;
      end
      ST_RESP: begin
        // hand the result to the output register once it is free
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_cell_d  = rd_hit_q ? rd_data_i : '0;
          out_cur_d   = CURSOR_W'(cur_q);
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      col_q       <= '0;
      ph_q        <= '0;
      cur_q       <= '0;
      sw_q        <= '0;
      pend_q      <= 1'b0;
      pa_q        <= '0;
      blank_q     <= 1'b0;
      clr_q       <= 1'b0;
      rd_hit_q    <= 1'b0;
      chr_q       <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_cell_q  <= '0;
      out_cur_q   <= '0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      col_q       <= col_d;
      ph_q        <= ph_d;
      cur_q       <= cur_d;
      sw_q        <= sw_d;
      pend_q      <= pend_d;
      pa_q        <= pa_d;
      blank_q     <= blank_d;
      clr_q       <= clr_d;
      rd_hit_q    <= rd_hit_d;
      chr_q       <= chr_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      out_cell_q  <= out_cell_d;
      out_cur_q   <= out_cur_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.cell_data       = out_cell_q;
  assign out_o.cursor_position = out_cur_q;

  // checks on position tracking and the sweep pipeline
  `TCW_ASSERT_NEVER(a_wp_range, wp_q > POS_W'(CELL_COUNT), "write position past cell count")
  `TCW_ASSERT_NEVER(a_col_range, col_q >= COL_W'(SCREEN_COLUMNS), "column counter out of range")
  `TCW_ASSERT_NEVER(a_rw_overlap, mem_o.we && mem_o.re && (mem_o.waddr == mem_o.raddr), "sweep reads a cell it writes")
  `TCW_ASSERT_PROP(a_sweep_drain, (state_q == ST_SWEEP && sw_q == POS_W'(CELL_COUNT)) |=> !pend_q, "sweep left a write pending")

endmodule

`default_nettype wire

[hw/rtl/text_console_writer_top.sv]
// top level of the text console writer: config registers, sequencer, screen ram
// depends on tcw_pkg, tcw_in_if, tcw_out_if, tcw_cfg, tcw_ctrl and tcw_ram
//
//   channel   dir   handshake          payload
//   in_i      in    valid/ready        func character last_char column row
//                                      place_fg place_bg read_index
//   out_o     out   valid/ready        cell_data cursor_position
//   cfg       in    cfg_we_i           cfg_idx_i cfg_data_i
//
// a non-scrolling put, a read and a place go from accept through the result state into
// the output register; clear and a scrolling put sweep the screen over the single
// write port of the screen ram, one cell a cycle
// reset clears the sequencer registers and sets the config defaults; screen cells hold nothing defined until written
// a stalled output beat holds the sequencer in its result state; the next beat is
// accepted while a finished result still waits in the output register
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer_top
  import tcw_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  tcw_in_if.sink                in_i,
  tcw_out_if.source             out_o
);

  cfg_t              cfg;
  mem_req_t          mem_req;
  logic [CELL_W-1:0] rd_data;

  // configuration registers
  tcw_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // sequencer
  tcw_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .in_i      (in_i),
    .out_o     (out_o),
    .mem_o     (mem_req),
    .rd_data_i (rd_data)
  );

  // screen cell store
  tcw_ram #(
    .Width (CELL_W),
    .Depth (CELL_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (rd_data)
  );

endmodule

`default_nettype wire
